// ===== sv/ptvd_pkg.sv =====
// Shared constants, payload types and register codes for point_to_volume_distance.
package ptvd_pkg;

    localparam int AXIS_BITS  = 20;
    localparam int AX_FRAC    = AXIS_BITS - 2;
    localparam int COORD_W    = 36;
    localparam int DIR_W      = 60;
    localparam int EXT_W      = 32;
    localparam int RAD_W      = 33;
    localparam int OUT_W      = 38;
    localparam int CFG_IDX_W  = 2;
    localparam int OFF_W      = COORD_W + 1;
    localparam int PROD_W     = OFF_W + AXIS_BITS;
    localparam int P_W        = PROD_W + 2;
    localparam int E_W        = EXT_W + AX_FRAC;
    localparam int X_W        = P_W + 1;
    localparam int D_W        = P_W - AX_FRAC + 1;
    localparam int HALF_W     = D_W / 2;
    localparam int SQ_W       = 2 * D_W;
    localparam int ROOT_W     = D_W;
    localparam int REM_W      = SQ_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_EYE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_Z = 2'd2;

    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_SPHERE = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } eye_t;

    typedef struct packed {
        logic                    kind;
        logic signed [RAD_W-1:0] radius;
        logic [2:0][D_W-1:0]     val;
    } front_out_t;

    typedef struct packed {
        logic                    kind;
        logic signed [RAD_W-1:0] radius;
        logic [SQ_W-1:0]         sum;
    } sq_out_t;

    typedef struct packed {
        logic                    kind;
        logic signed [RAD_W-1:0] radius;
        logic [ROOT_W-1:0]       root;
    } sqrt_out_t;

endpackage

// ===== sv/ptvd_ifs.sv =====
// Channel interfaces: volume input, distance output, configuration write.
interface ptvd_vol_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       volume_kind;
    logic signed [ptvd_pkg::COORD_W-1:0]        center_x;
    logic signed [ptvd_pkg::COORD_W-1:0]        center_y;
    logic signed [ptvd_pkg::COORD_W-1:0]        center_z;
    logic [ptvd_pkg::DIR_W-1:0]                 u_dir;
    logic [ptvd_pkg::DIR_W-1:0]                 v_dir;
    logic [ptvd_pkg::DIR_W-1:0]                 w_dir;
    logic [ptvd_pkg::EXT_W-1:0]                 u_extent;
    logic [ptvd_pkg::EXT_W-1:0]                 v_extent;
    logic [ptvd_pkg::EXT_W-1:0]                 w_extent;
    logic signed [ptvd_pkg::RAD_W-1:0]          sphere_radius;

    modport source(output valid, volume_kind, center_x, center_y, center_z, u_dir, v_dir,
                   w_dir, u_extent, v_extent, w_extent, sphere_radius, input ready);
    modport sink(input valid, volume_kind, center_x, center_y, center_z, u_dir, v_dir,
                 w_dir, u_extent, v_extent, w_extent, sphere_radius, output ready);
endinterface

interface ptvd_dist_if;
    logic                                valid;
    logic                                ready;
    logic signed [ptvd_pkg::OUT_W-1:0]   distance_out;

    modport source(output valid, distance_out, input ready);
    modport sink(input valid, distance_out, output ready);
endinterface

interface ptvd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ptvd_pkg::CFG_IDX_W-1:0]      index;
    logic [ptvd_pkg::COORD_W-1:0]        data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/ptvd_front.sv =====
// Front stages: eye offset, axis projections, clamp to extents, rounding; spheres pass the absolute offsets instead.
module ptvd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptvd_pkg::eye_t        eye,
    ptvd_vol_if.sink              vol,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ptvd_pkg::front_out_t  out_data
);

    localparam int S = 4;

    logic [S-1:0] valid_reg;
    logic [S-1:0] en;

    // stage 1
    logic                                   kind1_reg;
    logic signed [ptvd_pkg::RAD_W-1:0]      rad1_reg;
    logic signed [ptvd_pkg::OFF_W-1:0]      off1_reg [3];
    logic [2:0][ptvd_pkg::DIR_W-1:0]        dir1_reg;
    logic [2:0][ptvd_pkg::EXT_W-1:0]        ext1_reg;
    // stage 2
    logic                                   kind2_reg;
    logic signed [ptvd_pkg::RAD_W-1:0]      rad2_reg;
    logic signed [ptvd_pkg::PROD_W-1:0]     prod2_reg [3][3];
    logic [ptvd_pkg::D_W-1:0]               abs2_reg [3];
    logic [2:0][ptvd_pkg::EXT_W-1:0]        ext2_reg;
    // stage 3
    logic                                   kind3_reg;
    logic signed [ptvd_pkg::RAD_W-1:0]      rad3_reg;
    logic signed [ptvd_pkg::P_W-1:0]        p3_reg [3];
    logic [ptvd_pkg::D_W-1:0]               abs3_reg [3];
    logic [2:0][ptvd_pkg::EXT_W-1:0]        ext3_reg;
    // stage 4
    ptvd_pkg::front_out_t                   out4_reg;

    always_comb
    begin
        en[S-1] = !valid_reg[S-1] || out_ready;
        for (int i = S - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign vol.ready = en[0];
    assign out_valid = valid_reg[S-1];
    assign out_data  = out4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= vol.valid;
            for (int i = 1; i < S; i++)
            begin
                if (en[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // offsets
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            kind1_reg   <= vol.volume_kind;
            rad1_reg    <= vol.sphere_radius;
            off1_reg[0] <= ptvd_pkg::OFF_W'(eye.x) - ptvd_pkg::OFF_W'(vol.center_x);
            off1_reg[1] <= ptvd_pkg::OFF_W'(eye.y) - ptvd_pkg::OFF_W'(vol.center_y);
            off1_reg[2] <= ptvd_pkg::OFF_W'(eye.z) - ptvd_pkg::OFF_W'(vol.center_z);
            dir1_reg    <= {vol.w_dir, vol.v_dir, vol.u_dir};
            ext1_reg    <= {vol.w_extent, vol.v_extent, vol.u_extent};
        end
    end

    // products and magnitudes
    logic signed [ptvd_pkg::AXIS_BITS-1:0] comp [3][3];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                comp[a][j] = $signed(dir1_reg[a][j*ptvd_pkg::AXIS_BITS +: ptvd_pkg::AXIS_BITS]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            kind2_reg <= kind1_reg;
            rad2_reg  <= rad1_reg;
            ext2_reg  <= ext1_reg;
            for (int a = 0; a < 3; a++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod2_reg[a][j] <= ptvd_pkg::PROD_W'(off1_reg[j])
                                     * ptvd_pkg::PROD_W'(comp[a][j]);
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                abs2_reg[j] <= off1_reg[j][ptvd_pkg::OFF_W-1]
                             ? ptvd_pkg::D_W'(-off1_reg[j]) & ptvd_pkg::D_W'({ptvd_pkg::OFF_W{1'b1}})
                             : ptvd_pkg::D_W'(off1_reg[j]);
            end
        end
    end

    // projection sums
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            kind3_reg <= kind2_reg;
            rad3_reg  <= rad2_reg;
            ext3_reg  <= ext2_reg;
            abs3_reg  <= abs2_reg;
            for (int a = 0; a < 3; a++)
            begin
                p3_reg[a] <= ptvd_pkg::P_W'(prod2_reg[a][0]) + ptvd_pkg::P_W'(prod2_reg[a][1])
                           + ptvd_pkg::P_W'(prod2_reg[a][2]);
            end
        end
    end

    // clamp against the half extents and round
    logic signed [ptvd_pkg::X_W-1:0] pe   [3];
    logic signed [ptvd_pkg::X_W-1:0] ee   [3];
    logic signed [ptvd_pkg::X_W-1:0] xs   [3];
    logic [ptvd_pkg::X_W:0]          xr   [3];
    logic [2:0][ptvd_pkg::D_W-1:0]   dval;
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            pe[a] = ptvd_pkg::X_W'(p3_reg[a]);
            ee[a] = $signed(ptvd_pkg::X_W'({ext3_reg[a], {ptvd_pkg::AX_FRAC{1'b0}}}));
            if (pe[a] > ee[a])
                xs[a] = pe[a] - ee[a];
            else if (pe[a] < -ee[a])
                xs[a] = -ee[a] - pe[a];
            else
                xs[a] = '0;
            xr[a] = {1'b0, xs[a]} + ((ptvd_pkg::X_W+1)'(1) << (ptvd_pkg::AX_FRAC - 1));
            dval[a] = kind3_reg ? abs3_reg[a] : ptvd_pkg::D_W'(xr[a] >> ptvd_pkg::AX_FRAC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            out4_reg.kind   <= kind3_reg;
            out4_reg.radius <= rad3_reg;
            out4_reg.val    <= dval;
        end
    end

endmodule

// ===== sv/ptvd_square.sv =====
// Squaring stages: split partial products, then square assembly and sum.
module ptvd_square (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ptvd_pkg::front_out_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ptvd_pkg::sq_out_t     out_data
);

    localparam int S  = 3;
    localparam int H  = ptvd_pkg::HALF_W;
    localparam int HI = ptvd_pkg::D_W - H;

    logic [S-1:0] valid_reg;
    logic [S-1:0] en;

    logic                               kind1_reg, kind2_reg;
    logic signed [ptvd_pkg::RAD_W-1:0]  rad1_reg, rad2_reg;
    logic [2*HI-1:0]                    hh_reg [3];
    logic [HI+H-1:0]                    hl_reg [3];
    logic [2*H-1:0]                     ll_reg [3];
    logic [ptvd_pkg::SQ_W-1:0]          sq_reg [3];
    ptvd_pkg::sq_out_t                  out3_reg;

    always_comb
    begin
        en[S-1] = !valid_reg[S-1] || out_ready;
        for (int i = S - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[S-1];
    assign out_data  = out3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            for (int i = 1; i < S; i++)
            begin
                if (en[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            kind1_reg <= in_data.kind;
            rad1_reg  <= in_data.radius;
            for (int a = 0; a < 3; a++)
            begin
                hh_reg[a] <= (2*HI)'(in_data.val[a][ptvd_pkg::D_W-1:H])
                           * (2*HI)'(in_data.val[a][ptvd_pkg::D_W-1:H]);
                hl_reg[a] <= (HI+H)'(in_data.val[a][ptvd_pkg::D_W-1:H])
                           * (HI+H)'(in_data.val[a][H-1:0]);
                ll_reg[a] <= (2*H)'(in_data.val[a][H-1:0]) * (2*H)'(in_data.val[a][H-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            kind2_reg <= kind1_reg;
            rad2_reg  <= rad1_reg;
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= (ptvd_pkg::SQ_W'(hh_reg[a]) << (2*H))
                           + (ptvd_pkg::SQ_W'(hl_reg[a]) << (H+1))
                           + ptvd_pkg::SQ_W'(ll_reg[a]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            out3_reg.kind   <= kind2_reg;
            out3_reg.radius <= rad2_reg;
            out3_reg.sum    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

endmodule

// ===== sv/ptvd_sqrt.sv =====
// Square root pipeline: one root bit resolved per stage, most significant first.
module ptvd_sqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ptvd_pkg::sq_out_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ptvd_pkg::sqrt_out_t   out_data
);

    localparam int S = ptvd_pkg::ROOT_W;

    logic [S-1:0] valid_reg;
    logic [S-1:0] en;

    logic                               kind_reg [S];
    logic signed [ptvd_pkg::RAD_W-1:0]  rad_reg  [S];
    logic [ptvd_pkg::REM_W-1:0]         rem_reg  [S];
    logic [ptvd_pkg::ROOT_W-1:0]        root_reg [S];

    always_comb
    begin
        en[S-1] = !valid_reg[S-1] || out_ready;
        for (int i = S - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready         = en[0];
    assign out_valid        = valid_reg[S-1];
    assign out_data.kind    = kind_reg[S-1];
    assign out_data.radius  = rad_reg[S-1];
    assign out_data.root    = root_reg[S-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0]) valid_reg[0] <= in_valid;
            for (int i = 1; i < S; i++)
            begin
                if (en[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < S; k++)
        begin : g_stage
            localparam int B = S - 1 - k;
            logic                              kind_in;
            logic signed [ptvd_pkg::RAD_W-1:0] rad_in;
            logic [ptvd_pkg::REM_W-1:0]        rem_in;
            logic [ptvd_pkg::ROOT_W-1:0]       root_in;
            logic [ptvd_pkg::REM_W-1:0]        trial;

            if (k == 0)
            begin : g_first
                assign kind_in = in_data.kind;
                assign rad_in  = in_data.radius;
                assign rem_in  = ptvd_pkg::REM_W'(in_data.sum);
                assign root_in = '0;
            end
            else
            begin : g_next
                assign kind_in = kind_reg[k-1];
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            assign trial = (ptvd_pkg::REM_W'(root_in) << (B + 1))
                         | (ptvd_pkg::REM_W'(1) << (2 * B));

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    kind_reg[k] <= kind_in;
                    rad_reg[k]  <= rad_in;
                    if (rem_in >= trial)
                    begin
                        rem_reg[k]  <= rem_in - trial;
                        root_reg[k] <= root_in | (ptvd_pkg::ROOT_W'(1) << B);
                    end
                    else
                    begin
                        rem_reg[k]  <= rem_in;
                        root_reg[k] <= root_in;
                    end
                end
            end
        end
    endgenerate

endmodule

// ===== sv/point_to_volume_distance.sv =====
// Top level: eye registers, front, squaring and root pipelines, output stage.
//
//   channel  modport  payload
//   vol      sink     volume_kind, center_x/y/z, u/v/w_dir, u/v/w_extent, sphere_radius
//   dout     source   distance_out
//   cfg      sink     index, data (eye_x, eye_y, eye_z)
//
// One transaction per cycle sustained while dout.ready stays high. Stages: 4 front, 3 squaring,
// 42 root, 1 output register. The root pipeline sets the depth.
// Reset clears valid bits and eye registers to zero.
// Each stage holds while full and blocked downstream; bubbles collapse.
module point_to_volume_distance (
    input  logic          clk,
    input  logic          rst_n,
    ptvd_vol_if.sink      vol,
    ptvd_dist_if.source   dout,
    ptvd_cfg_if.sink      cfg
);

    localparam logic signed [ptvd_pkg::OUT_W-1:0] MAX_OUT = {1'b0, {(ptvd_pkg::OUT_W-1){1'b1}}};
    localparam logic signed [ptvd_pkg::OUT_W-1:0] MIN_OUT = {1'b1, {(ptvd_pkg::OUT_W-1){1'b0}}};
    localparam int DIFF_W = ptvd_pkg::ROOT_W + 2;

    ptvd_pkg::eye_t         eye_reg;
    logic                   f_valid, f_ready;
    ptvd_pkg::front_out_t   f_data;
    logic                   q_valid, q_ready;
    ptvd_pkg::sq_out_t      q_data;
    logic                   r_valid, r_ready;
    ptvd_pkg::sqrt_out_t    r_data;

    logic                               out_valid_reg;
    logic signed [ptvd_pkg::OUT_W-1:0]  out_reg;
    logic signed [ptvd_pkg::OUT_W-1:0]  out_next;
    logic signed [DIFF_W-1:0]           diff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ptvd_pkg::REG_EYE_X: eye_reg.x <= $signed(cfg.data);
                ptvd_pkg::REG_EYE_Y: eye_reg.y <= $signed(cfg.data);
                ptvd_pkg::REG_EYE_Z: eye_reg.z <= $signed(cfg.data);
                default: ;
            endcase
        end
    end

    ptvd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .eye       (eye_reg),
        .vol       (vol),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    ptvd_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    ptvd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_data  (r_data)
    );

    assign r_ready = !out_valid_reg || dout.ready;

    always_comb
    begin
        diff = $signed({2'b00, r_data.root}) - DIFF_W'(r_data.radius);
        if (r_data.kind == ptvd_pkg::KIND_BOX)
        begin
            if (r_data.root > ptvd_pkg::ROOT_W'(MAX_OUT))
                out_next = MAX_OUT;
            else
                out_next = ptvd_pkg::OUT_W'(r_data.root);
        end
        else if (r_data.radius < 0)
        begin
            out_next = MAX_OUT;
        end
        else if (diff > DIFF_W'(MAX_OUT))
        begin
            out_next = MAX_OUT;
        end
        else if (diff < DIFF_W'(MIN_OUT))
        begin
            out_next = MIN_OUT;
        end
        else
        begin
            out_next = ptvd_pkg::OUT_W'(diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (r_ready)
        begin
            out_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_ready)
        begin
            out_reg <= out_next;
        end
    end

    assign dout.valid        = out_valid_reg;
    assign dout.distance_out = out_reg;

endmodule

// ===== tb/point_to_volume_distance_tb.sv =====
// Self-checking testbench for point_to_volume_distance: directed table, random volumes, eye sweeps.
module point_to_volume_distance_tb;

    typedef struct {
        logic                                kind;
        logic signed [ptvd_pkg::COORD_W-1:0] cx, cy, cz;
        logic [ptvd_pkg::DIR_W-1:0]          ud, vd, wd;
        logic [ptvd_pkg::EXT_W-1:0]          ue, ve, we;
        logic signed [ptvd_pkg::RAD_W-1:0]   rad;
    } volume_t;

    typedef struct {
        volume_t                           vol;
        logic                              typed;
        logic signed [ptvd_pkg::OUT_W-1:0] want;
    } row_t;

    localparam logic signed [ptvd_pkg::OUT_W-1:0] DIST_MAX = {1'b0, {(ptvd_pkg::OUT_W-1){1'b1}}};
    localparam logic [ptvd_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ptvd_vol_if  vol();
    ptvd_dist_if dout();
    ptvd_cfg_if  cfg();

    point_to_volume_distance uut (
        .clk   (clk),
        .rst_n (rst_n),
        .vol   (vol.sink),
        .dout  (dout.sink),
        .cfg   (cfg.sink)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic signed [ptvd_pkg::COORD_W-1:0] eye_pos [3];
    logic signed [ptvd_pkg::OUT_W-1:0]   pending_dist [$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;
    bit  hold_off = 1'b0;

    function automatic logic [40:0] floor_root(logic [127:0] s);
        logic [40:0]  r;
        logic [40:0]  t;
        logic [127:0] sq;
        r = '0;
        for (int b = 40; b >= 0; b--)
        begin
            t = r | (41'd1 << b);
            sq = 128'(t) * 128'(t);
            if (sq <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] axis_excess(longint off [3],
                                                logic [ptvd_pkg::DIR_W-1:0] dir,
                                                logic [ptvd_pkg::EXT_W-1:0] ext);
        longint      p;
        longint      e;
        logic [63:0] x;
        p = 0;
        for (int i = 0; i < 3; i++)
            p += off[i] * longint'($signed(dir[i*ptvd_pkg::AXIS_BITS +: ptvd_pkg::AXIS_BITS]));
        e = longint'({32'd0, ext}) <<< ptvd_pkg::AX_FRAC;
        x = '0;
        if (p > e)
            x = p - e;
        else if (p < -e)
            x = -e - p;
        return (x + (64'd1 << (ptvd_pkg::AX_FRAC - 1))) >> ptvd_pkg::AX_FRAC;
    endfunction

    function automatic logic signed [ptvd_pkg::OUT_W-1:0] eye_distance(volume_t v);
        longint       off [3];
        logic [63:0]  d [3];
        logic [127:0] s;
        logic [40:0]  r;
        longint       res;
        off[0] = longint'(eye_pos[0]) - longint'(v.cx);
        off[1] = longint'(eye_pos[1]) - longint'(v.cy);
        off[2] = longint'(eye_pos[2]) - longint'(v.cz);
        if (v.kind == ptvd_pkg::KIND_BOX)
        begin
            d[0] = axis_excess(off, v.ud, v.ue);
            d[1] = axis_excess(off, v.vd, v.ve);
            d[2] = axis_excess(off, v.wd, v.we);
            s = '0;
            for (int i = 0; i < 3; i++)
                s += 128'(d[i]) * 128'(d[i]);
            r = floor_root(s);
            return (r > 41'(DIST_MAX)) ? DIST_MAX : ptvd_pkg::OUT_W'(r);
        end
        if (v.rad < 0)
            return DIST_MAX;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = (off[i] < 0) ? -off[i] : off[i];
            s += 128'(d[i]) * 128'(d[i]);
        end
        res = longint'(floor_root(s)) - longint'(v.rad);
        if (res > longint'(DIST_MAX))
            res = DIST_MAX;
        if (res < -longint'(DIST_MAX) - 1)
            res = -longint'(DIST_MAX) - 1;
        return ptvd_pkg::OUT_W'(res);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ptvd_pkg::DIR_W-1:0] rand_axes();
        logic [ptvd_pkg::DIR_W-1:0] a;
        a = ptvd_pkg::DIR_W'(rand64());
        if ($urandom_range(0, 2) != 0)
        begin
            a = '0;
            a[$urandom_range(0, 2)*ptvd_pkg::AXIS_BITS +: ptvd_pkg::AXIS_BITS] =
                $urandom_range(0, 1) ? ptvd_pkg::AXIS_BITS'(1 << ptvd_pkg::AX_FRAC)
                                     : -ptvd_pkg::AXIS_BITS'(1 << ptvd_pkg::AX_FRAC);
        end
        return a;
    endfunction

    function automatic volume_t rand_volume();
        volume_t v;
        bit near;
        near = $urandom_range(0, 3) != 0;
        v.kind = 1'($urandom_range(0, 1));
        v.cx = near ? eye_pos[0] + ptvd_pkg::COORD_W'($signed(20'($urandom)))
                    : ptvd_pkg::COORD_W'(rand64());
        v.cy = near ? eye_pos[1] + ptvd_pkg::COORD_W'($signed(20'($urandom)))
                    : ptvd_pkg::COORD_W'(rand64());
        v.cz = near ? eye_pos[2] + ptvd_pkg::COORD_W'($signed(20'($urandom)))
                    : ptvd_pkg::COORD_W'(rand64());
        v.ud = rand_axes();
        v.vd = rand_axes();
        v.wd = rand_axes();
        v.ue = near ? $urandom_range(0, 300000) : $urandom;
        v.ve = near ? $urandom_range(0, 300000) : $urandom;
        v.we = near ? $urandom_range(0, 300000) : $urandom;
        v.rad = near ? ptvd_pkg::RAD_W'($urandom_range(0, 400000))
                     : ptvd_pkg::RAD_W'(rand64());
        return v;
    endfunction

    task automatic send_volume(volume_t v, logic typed,
                               logic signed [ptvd_pkg::OUT_W-1:0] want);
        if (!steady && $urandom_range(0, 99) < 9)
        begin
            @(negedge clk);
            vol.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        else
            @(negedge clk);
        vol.valid         <= 1'b1;
        vol.volume_kind   <= v.kind;
        vol.center_x      <= v.cx;
        vol.center_y      <= v.cy;
        vol.center_z      <= v.cz;
        vol.u_dir         <= v.ud;
        vol.v_dir         <= v.vd;
        vol.w_dir         <= v.wd;
        vol.u_extent      <= v.ue;
        vol.v_extent      <= v.ve;
        vol.w_extent      <= v.we;
        vol.sphere_radius <= v.rad;
        do @(posedge clk); while (!vol.ready);
        pending_dist.push_back(typed ? want : eye_distance(v));
    endtask

    task automatic write_eye(logic [ptvd_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptvd_pkg::COORD_W-1:0] value);
        @(negedge clk);
        vol.valid  <= 1'b0;
        cfg.valid  <= 1'b1;
        cfg.index  <= idx;
        cfg.data   <= value;
        do @(posedge clk); while (!cfg.ready);
        if (idx != REG_NONE)
            eye_pos[idx] = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        vol.valid <= 1'b0;
        wait (pending_dist.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_eye(logic [ptvd_pkg::COORD_W-1:0] x, logic [ptvd_pkg::COORD_W-1:0] y,
                           logic [ptvd_pkg::COORD_W-1:0] z);
        drain();
        write_eye(ptvd_pkg::REG_EYE_X, x);
        write_eye(ptvd_pkg::REG_EYE_Y, y);
        write_eye(ptvd_pkg::REG_EYE_Z, z);
    endtask

    // receiver
    initial
    begin
        dout.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                dout.ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            dout.ready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && dout.valid && dout.ready)
        begin
            if (pending_dist.size() == 0)
            begin
                $error("distance_out: unexpected transaction, actual %0d", dout.distance_out);
                fail_count++;
            end
            else
            begin
                if (dout.distance_out !== pending_dist[0])
                begin
                    $error("distance_out: expected %0d, actual %0d",
                           pending_dist[0], dout.distance_out);
                    fail_count++;
                end
                void'(pending_dist.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((vol.valid && vol.ready) || (dout.valid && dout.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t    rows [$];
        row_t    r;
        volume_t z;

        vol.valid = 1'b0;
        vol.volume_kind = ptvd_pkg::KIND_BOX;
        vol.center_x = '0;
        vol.center_y = '0;
        vol.center_z = '0;
        vol.u_dir = '0;
        vol.v_dir = '0;
        vol.w_dir = '0;
        vol.u_extent = '0;
        vol.v_extent = '0;
        vol.w_extent = '0;
        vol.sphere_radius = '0;
        cfg.valid = 1'b0;
        cfg.index = ptvd_pkg::REG_EYE_X;
        cfg.data = '0;
        for (int i = 0; i < 3; i++)
            eye_pos[i] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        z = '{kind: ptvd_pkg::KIND_BOX, cx: 0, cy: 0, cz: 0, ud: 0, vd: 0, wd: 0,
              ue: 0, ve: 0, we: 0, rad: 0};
        // eye at reset origin
        r = '{vol: z, typed: 1'b1, want: 0};
        rows.push_back(r);
        r.vol.kind = ptvd_pkg::KIND_SPHERE;
        r.vol.rad = -1;
        r.want = DIST_MAX;
        rows.push_back(r);
        r.vol.rad = {1'b1, 32'd0};
        rows.push_back(r);
        r.vol.rad = 33'd4294967295;
        r.want = -38'sd4294967295;
        rows.push_back(r);
        r.vol.rad = 0;
        r.want = 0;
        rows.push_back(r);
        r = '{vol: z, typed: 1'b1, want: 0};
        r.vol.ud = '1;
        r.vol.vd = '1;
        r.vol.wd = '1;
        r.vol.ue = '1;
        r.vol.ve = '1;
        r.vol.we = '1;
        r.vol.rad = {1'b1, 32'd0};
        rows.push_back(r);
        // far corners, checked by prediction
        r = '{vol: z, typed: 1'b0, want: 0};
        r.vol.cx = {1'b1, 35'd0};
        r.vol.cy = {1'b1, 35'd0};
        r.vol.cz = {1'b1, 35'd0};
        r.vol.ud = {3{20'h40000}};
        r.vol.vd = {3{20'h80000}};
        r.vol.wd = {3{20'h7FFFF}};
        rows.push_back(r);
        r.vol.kind = ptvd_pkg::KIND_SPHERE;
        rows.push_back(r);
        r.vol.rad = 33'd4294967295;
        rows.push_back(r);
        r.vol.cx = {1'b0, {35{1'b1}}};
        r.vol.cy = {1'b0, {35{1'b1}}};
        r.vol.cz = {1'b0, {35{1'b1}}};
        rows.push_back(r);
        r.vol.kind = ptvd_pkg::KIND_BOX;
        r.vol.ue = 32'd1000;
        rows.push_back(r);
        r.vol.ud = {20'h40000, 20'h0, 20'h0};
        r.vol.vd = {20'h0, 20'h40000, 20'h0};
        r.vol.wd = {20'h0, 20'h0, 20'hC0000};
        rows.push_back(r);

        foreach (rows[i])
            send_volume(rows[i].vol, rows[i].typed, rows[i].want);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: ;
                1: set_eye({1'b0, {35{1'b1}}}, {1'b0, {35{1'b1}}}, {1'b0, {35{1'b1}}});
                2: set_eye({1'b1, 35'd0}, {1'b1, 35'd0}, {1'b1, 35'd0});
                3:
                begin
                    set_eye(ptvd_pkg::COORD_W'(rand64()), ptvd_pkg::COORD_W'(rand64()),
                            ptvd_pkg::COORD_W'(rand64()));
                    write_eye(REG_NONE, ptvd_pkg::COORD_W'(rand64()));
                end
                default: set_eye(ptvd_pkg::COORD_W'(rand64()), ptvd_pkg::COORD_W'(rand64()),
                                 ptvd_pkg::COORD_W'(rand64()));
            endcase
            steady = (phase == 4);
            for (int n = 0; n < 140; n++)
            begin
                if (phase == 2 && n == 20)
                    hold_off = 1'b1;
                send_volume(rand_volume(), 1'b0, '0);
            end
        end

        @(negedge clk);
        vol.valid <= 1'b0;
        wait (pending_dist.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ptvd_pkg.sv
sv/ptvd_ifs.sv
sv/ptvd_front.sv
sv/ptvd_square.sv
sv/ptvd_sqrt.sv
sv/point_to_volume_distance.sv
tb/point_to_volume_distance_tb.sv
